@@ hdl/char_lcd_4bit_interface_defines.svh @@
// Assertion macros shared by the character LCD interface modules.
`ifndef CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH
`define CHAR_LCD_4BIT_INTERFACE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define CLCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that, once seen, must be followed in the next cycle by a consequence.
`define CLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/clcd_pkg.sv @@
// Shared types, constants and functions of the character LCD interface.
`default_nettype none
package clcd_pkg;

  // Width of the tick counter; every wait saturates to 2^CounterWidth ticks.
  localparam int unsigned CounterWidth = 20;
  localparam int unsigned PulseW       = 16;
  localparam int unsigned StartupW     = 20;
  localparam int unsigned CfgDataW     = 20;
  // Durations need one bit above both the counter and the startup register.
  localparam int unsigned DurW =
      ((CounterWidth > StartupW) ? CounterWidth : StartupW) + 1;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;

  // Configuration register indexes.
  localparam logic [0:0] RegPulseTicks   = 1'b0;
  localparam logic [0:0] RegStartupTicks = 1'b1;

  localparam logic [PulseW-1:0]   PulseTicksReset   = PulseW'(4200);
  localparam logic [StartupW-1:0] StartupTicksReset = StartupW'(50000);

  // One result per tick; enable_pin sits in bit 0.
  typedef struct packed {
    logic       init_done;
    logic       accepted;
    logic       busy_res;
    logic [3:0] data_nibble;
    logic       select_pin;
    logic       enable_pin;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

  // One segment of the power-up sequence.
  typedef struct packed {
    logic [3:0] nib;
    logic       en;
    logic       double_len;
  } init_seg_t;

  // Power-up sequence: 3, 3, 3, 2, then 0x28, 0x0C, 0x01, 0x06 high nibble first.
  // Each nibble is an enable-high segment and an enable-low segment; the low
  // segment closing each item lasts two pulse units.
  function automatic init_seg_t init_seg(input logic [4:0] k);
    init_seg_t s;
    s.en         = ~k[0];
    s.double_len = 1'b0;
    case (k)
      5'd0, 5'd2, 5'd4:             s.nib = 4'h3;
      5'd1, 5'd3, 5'd5: begin
        s.nib        = 4'h3;
        s.double_len = 1'b1;
      end
      5'd6, 5'd8, 5'd9:             s.nib = 4'h2;
      5'd7: begin
        s.nib        = 4'h2;
        s.double_len = 1'b1;
      end
      5'd10:                        s.nib = 4'h8;
      5'd11: begin
        s.nib        = 4'h8;
        s.double_len = 1'b1;
      end
      5'd12, 5'd13, 5'd16, 5'd17,
      5'd20, 5'd21:                 s.nib = 4'h0;
      5'd14:                        s.nib = 4'hC;
      5'd15: begin
        s.nib        = 4'hC;
        s.double_len = 1'b1;
      end
      5'd18:                        s.nib = 4'h1;
      5'd19: begin
        s.nib        = 4'h1;
        s.double_len = 1'b1;
      end
      5'd22:                        s.nib = 4'h6;
      5'd23: begin
        s.nib        = 4'h6;
        s.double_len = 1'b1;
      end
      default:                      s.nib = 4'h0;
    endcase
    return s;
  endfunction

  // Clamp a wait to the counter's range.
  function automatic logic [DurW-1:0] sat_dur(input logic [DurW-1:0] d);
    logic [DurW-1:0] lim;
    lim = DurW'(1) << CounterWidth;
    return (d > lim) ? lim : d;
  endfunction

endpackage
`default_nettype wire

@@ hdl/clcd_seq.sv @@
// Tick sequencer: phase, tick counter and pin state, one step per accepted tick.
`default_nettype none
`include "char_lcd_4bit_interface_defines.svh"
module clcd_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_en_i,
  input  wire logic                          write_request_i,
  input  wire logic [7:0]                    byte_value_i,
  input  wire logic                          register_select_i,
  input  wire logic [clcd_pkg::PulseW-1:0]   pulse_ticks_i,
  input  wire logic [clcd_pkg::StartupW-1:0] startup_ticks_i,
  output clcd_pkg::res_t                     res_o
);

  localparam int unsigned CntW = clcd_pkg::CounterWidth;
  localparam int unsigned DurW = clcd_pkg::DurW;

  localparam logic [4:0] PhStart     = 5'd0;
  localparam logic [4:0] PhInitFirst = 5'd1;
  localparam logic [4:0] PhInitLast  = 5'd24;
  localparam logic [4:0] PhIdle      = 5'd25;
  localparam logic [4:0] PhSendFirst = 5'd26;
  localparam logic [4:0] PhSendLast  = 5'd29;

  logic [4:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      byte_q, byte_d;
  logic            sel_q, sel_d;
  logic [3:0]      nib_q, nib_d;
  logic            strobe_q, strobe_d;

  logic [4:0]                ph_start;
  logic [4:0]                ph;
  logic [CntW-1:0]           cnt_mid;
  logic [CntW:0]             cnt_inc;
  logic [clcd_pkg::PulseW-1:0] pulse_eff;
  logic [DurW-1:0]           startup_dur;
  logic [DurW-1:0]           dur;
  logic [4:0]                init_k;
  logic [1:0]                send_k;
  clcd_pkg::init_seg_t       seg;
  logic                      acc;

  assign pulse_eff   = (pulse_ticks_i == '0) ? clcd_pkg::PulseW'(1) : pulse_ticks_i;
  assign startup_dur = clcd_pkg::sat_dur(DurW'(startup_ticks_i));
  assign ph_start    = (phase_q > PhSendLast) ? PhIdle : phase_q;

  always_comb begin
    ph      = ph_start;
    cnt_mid = cnt_q;
    byte_d  = byte_q;
    sel_d   = sel_q;
    acc     = 1'b0;
    // Startup wait already elapsed (covers a zero startup wait).
    if (ph == PhStart && DurW'(cnt_q) >= startup_dur) begin
      ph      = PhInitFirst;
      cnt_mid = '0;
    end
    if (ph == PhIdle && write_request_i) begin
      byte_d  = byte_value_i;
      sel_d   = register_select_i;
      ph      = PhSendFirst;
      cnt_mid = '0;
      acc     = 1'b1;
    end

    init_k  = ph - PhInitFirst;
    send_k  = 2'(ph - PhSendFirst);
    seg     = clcd_pkg::init_seg(init_k);
    cnt_inc = {1'b0, cnt_mid} + (CntW + 1)'(1);

    dur      = '0;
    nib_d    = nib_q;
    strobe_d = 1'b0;
    if (ph == PhStart) begin
      dur = startup_dur;
    end else if (ph <= PhInitLast) begin
      sel_d    = 1'b0;
      nib_d    = seg.nib;
      strobe_d = seg.en;
      dur      = clcd_pkg::sat_dur(seg.double_len ? DurW'({pulse_eff, 1'b0})
                                                  : DurW'(pulse_eff));
    end else if (ph >= PhSendFirst) begin
      nib_d    = send_k[1] ? byte_d[3:0] : byte_d[7:4];
      strobe_d = ~send_k[0];
      dur      = clcd_pkg::sat_dur(DurW'(pulse_eff));
    end

    phase_d = ph;
    cnt_d   = cnt_mid;
    if (ph != PhIdle) begin
      cnt_d = cnt_inc[CntW-1:0];
      // Advance on wrap or when the segment has run its length.
      if (cnt_d == '0 || DurW'(cnt_d) >= dur) begin
        phase_d = (ph == PhSendLast) ? PhIdle : ph + 5'd1;
        cnt_d   = '0;
      end
    end

    res_o.enable_pin  = strobe_d;
    res_o.select_pin  = sel_d;
    res_o.data_nibble = nib_d;
    res_o.busy_res    = (ph != PhIdle);
    res_o.accepted    = acc;
    res_o.init_done   = (ph >= PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      cnt_q    <= '0;
      byte_q   <= '0;
      sel_q    <= 1'b0;
      nib_q    <= '0;
      strobe_q <= 1'b0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      byte_q   <= byte_d;
      sel_q    <= sel_d;
      nib_q    <= nib_d;
      strobe_q <= strobe_d;
    end
  end

  `CLCD_ASSERT(a_phase_legal, clk_i, rst_ni, phase_q <= PhSendLast, "phase code out of range")
  `CLCD_ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, phase_q >= PhIdle, phase_q >= PhIdle, "init done lost")
  `CLCD_ASSERT_NEXT(a_accept_sends, clk_i, rst_ni, step_en_i && res_o.accepted, phase_q >= PhSendFirst, "accepted byte not sending")

endmodule
`default_nettype wire

@@ hdl/clcd_skid.sv @@
// Output register with a skid stage so the input side can hand over one more result under a stall.
`default_nettype none
`include "char_lcd_4bit_interface_defines.svh"
module clcd_skid (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  clcd_pkg::res_t      in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output clcd_pkg::res_t      out_data_o
);

  logic           out_v_q, out_v_d;
  logic           skid_v_q, skid_v_d;
  clcd_pkg::res_t out_q, out_d;
  clcd_pkg::res_t skid_q, skid_d;
  logic           in_fire;

  assign in_ready_o  = ~skid_v_q;
  assign in_fire     = in_valid_i & ~skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        // Drain the skid entry first.
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = in_fire;
        out_d   = in_data_i;
      end
    end else if (in_fire) begin
      // Output stalled: park the new result.
      skid_v_d = 1'b1;
      skid_d   = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `CLCD_ASSERT(a_skid_behind_out, clk_i, rst_ni, !skid_v_q || out_v_q, "skid full with empty output")
  `CLCD_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_v_q && out_ready_i, !skid_v_q, "skid did not drain")

endmodule
`default_nettype wire

@@ hdl/char_lcd_4bit_interface.sv @@
// Top level of the 4-bit character LCD host interface.
//
//  Port group   Dir  Transfer when                  Contents
//  s_axis_*     in   s_axis_tvalid_i & tready_o     one time tick, optional byte request
//  m_axis_*     out  m_axis_tvalid_o & tready_i     pin levels and status for that tick
//  cfg_*        in   cfg_valid_i & cfg_ready_o      register write (always ready)
//
// One tick is taken per clock cycle; its result goes to the output register
// (or the skid entry). The step logic is one pass through the phase and counter
// update, so nothing limits the rate but output back-pressure. A two-entry
// output stage (register plus skid) keeps s_axis_tready_o high until both hold
// results. Reset puts the sequencer in its startup wait with all lines low.
`default_nettype none
module char_lcd_4bit_interface (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [0] write_request, [8:1] byte_value, [15:9] zero
  input  wire logic [clcd_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [0] register_select
  input  wire logic                           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [0] enable_pin, [1] select_pin, [5:2] data_nibble, [6] busy_res,
  // [7] accepted, [8] init_done, [15:9] zero
  output logic [clcd_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [0:0]                     cfg_index_i,
  input  wire logic [clcd_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [clcd_pkg::PulseW-1:0]   pulse_q;
  logic [clcd_pkg::StartupW-1:0] startup_q;
  logic                          in_fire;
  logic                          cfg_fire;
  clcd_pkg::res_t                step_res;
  clcd_pkg::res_t                out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q   <= clcd_pkg::PulseTicksReset;
      startup_q <= clcd_pkg::StartupTicksReset;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        clcd_pkg::RegPulseTicks:   pulse_q   <= cfg_data_i[clcd_pkg::PulseW-1:0];
        clcd_pkg::RegStartupTicks: startup_q <= cfg_data_i[clcd_pkg::StartupW-1:0];
        default: ;
      endcase
    end
  end

  clcd_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_en_i         (in_fire),
    .write_request_i   (s_axis_tdata_i[0]),
    .byte_value_i      (s_axis_tdata_i[8:1]),
    .register_select_i (s_axis_tuser_i),
    .pulse_ticks_i     (pulse_q),
    .startup_ticks_i   (startup_q),
    .res_o             (step_res)
  );

  clcd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (step_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {(clcd_pkg::OutTdataW - clcd_pkg::ResW)'(0), out_res};

endmodule
`default_nettype wire
